### rtl/kpe_pkg.sv
// ----------------------------------------------------------------------------
// kpe_pkg
// Shared types and constants of the keyframe path evaluator.
// ----------------------------------------------------------------------------
package kpe_pkg;

  // default table geometry
  localparam int MaxSegmentsDef = 256;
  localparam int NumChannelsDef = 7;

  // item operations
  localparam logic [1:0] OpWrTime = 2'd0;
  localparam logic [1:0] OpWrChan = 2'd1;
  localparam logic [1:0] OpWrPose = 2'd2;
  localparam logic [1:0] OpEval   = 2'd3;

  // channel interpolation kinds (any other code holds the left value)
  localparam logic [1:0] KindLinear  = 2'd1;
  localparam logic [1:0] KindHermite = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegPathValid = 2'd0;
  localparam logic [1:0] RegSegCount  = 2'd1;
  localparam logic [1:0] RegFirstTime = 2'd2;
  localparam logic [1:0] RegLastTime  = 2'd3;

  // one channel entry of the table
  typedef struct packed {
    logic [1:0]  kind;
    logic        clamp;
    logic [47:0] left;
    logic [47:0] right;
    logic [47:0] lslope;
    logic [47:0] rslope;
  } chan_entry_t;

  // per-query coefficients handed to the channel evaluator
  typedef struct packed {
    logic [15:0]        u;
    logic [31:0]        span;
    logic signed [17:0] h00;
    logic signed [17:0] h10;
    logic signed [17:0] h01;
    logic signed [17:0] h11;
  } coef_t;

  // sequencer states, one-hot
  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_STATUS   = 13'b0000000000010,
    S_POSE_RD  = 13'b0000000000100,
    S_POSE_OUT = 13'b0000000001000,
    S_SRCH     = 13'b0000000010000,
    S_SRCH_CMP = 13'b0000000100000,
    S_SEG_WAIT = 13'b0000001000000,
    S_DIV      = 13'b0000010000000,
    S_U2       = 13'b0000100000000,
    S_U3       = 13'b0001000000000,
    S_BASIS    = 13'b0010000000000,
    S_CH_RD    = 13'b0100000000000,
    S_CH_EVAL  = 13'b1000000000000
  } state_e;

endpackage

### rtl/keyframe_path_evaluator.sv
// ----------------------------------------------------------------------------
// keyframe_path_evaluator
// Keyframe path table evaluated as a piecewise cubic Hermite spline.
// ----------------------------------------------------------------------------
// Use: an item is taken when start is high and busy is low. Write items
// (segment times, channel entries, endpoint poses) leave the block idle and
// give no result. An evaluate item gives one result per channel (seven by
// default) on result_valid_o, each shown for one cycle; last_of_pose_o marks
// the final one. With no path loaded it gives a single result with status 1,
// passed through the S_STATUS state and the result register.
// Steps: a pose answer reads each channel's pose and registers it as a result.
// An interpolated answer bisects the segment memory (at most ceil(log2(n+1))
// steps), reads the final segment, runs the bit-serial phase division (16
// quotient bits), forms the powers and basis, and then for each channel does
// an entry read, a start, twelve steps of the one shared 48x18 multiplier that
// forms ten products, and a done flag. The receiver cannot stall the results.
// Items are handled one at a time; busy stays high until the last result.
// Registers are to be written through the APB port only while the block is
// idle; the block does not enforce this. Reset clears the registers and the
// sequencer; the memories keep no reset and must be written before use.
// ----------------------------------------------------------------------------
module keyframe_path_evaluator #(
  parameter int MAX_SEGMENTS = kpe_pkg::MaxSegmentsDef,
  parameter int NUM_CHANNELS = kpe_pkg::NumChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // items
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  segment_index_i,
  input  logic [2:0]  channel_index_i,
  input  logic [31:0] begin_time_i,
  input  logic [31:0] end_time_i,
  input  logic [1:0]  interp_kind_i,
  input  logic        clamp_enable_i,
  input  logic [47:0] left_value_i,
  input  logic [47:0] right_value_i,
  input  logic [47:0] left_slope_i,
  input  logic [47:0] right_slope_i,
  input  logic [31:0] query_time_i,
  // results
  output logic        result_valid_o,
  output logic [2:0]  out_channel_o,
  output logic [47:0] channel_value_o,
  output logic        status_o,
  output logic        last_of_pose_o
);

  localparam int SegW = $clog2(MAX_SEGMENTS);
  localparam int ChW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int EntW = $clog2(MAX_SEGMENTS * NUM_CHANNELS);
  localparam int CntW = $clog2(MAX_SEGMENTS + 1);

  // configuration registers
  logic        path_valid_q;
  logic [7:0]  seg_count_q;
  logic [31:0] first_q;
  logic [31:0] last_q;

  kpe_pkg::state_e state_q;
  logic [31:0]     t_q;
  logic [CntW-1:0] low_q, high_q, mid_q;
  logic [SegW-1:0] idx_q;
  logic [ChW-1:0]  ch_q;
  logic            pose_end_q;
  logic [15:0]     u_q, u2_q, u3_q;
  logic [31:0]     span_q;
  logic signed [17:0] h00_q, h10_q, h01_q, h11_q;
  logic            ev_start_q;

  logic            res_valid_q;
  logic [2:0]      res_ch_q;
  logic [47:0]     res_val_q;
  logic            res_st_q;
  logic            res_last_q;

  logic            accept;
  logic            cfg_wr;
  logic            seg_ok, ch_ok;
  logic [CntW-1:0] n_c, mid_c;
  logic            last_ch;

  logic        seg_we, seg_re;
  logic [SegW-1:0] seg_raddr;
  logic [31:0] seg_rbegin, seg_rend;
  logic        chan_we, chan_re;
  kpe_pkg::chan_entry_t chan_wdata, chan_rdata;
  logic [EntW-1:0] chan_waddr, chan_raddr;
  logic        pose_we, pose_re;
  logic [47:0] pose_rstart, pose_rend;

  logic        div_done;
  logic [15:0] div_u;
  logic [31:0] div_span;
  logic        ev_done;
  logic [47:0] ev_value;
  kpe_pkg::coef_t coef;

  logic [31:0] usq, u2u;
  logic signed [19:0] us, u2s, u3s;

  // hold a basis value to [-1, 1] in Q16
  function automatic logic signed [17:0] hold_basis(input logic signed [19:0] h);
    if (h > 20'sd65536) begin
      return 18'sd65536;
    end else if (h < -20'sd65536) begin
      return -18'sd65536;
    end else begin
      return 18'(h);
    end
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_q != kpe_pkg::S_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // configuration writes and reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_valid_q <= 1'b0;
      seg_count_q  <= '0;
      first_q      <= '0;
      last_q       <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        kpe_pkg::RegPathValid: path_valid_q <= pwdata[0];
        kpe_pkg::RegSegCount:  seg_count_q  <= pwdata[7:0];
        kpe_pkg::RegFirstTime: first_q      <= pwdata;
        kpe_pkg::RegLastTime:  last_q       <= pwdata;
        default:               last_q       <= last_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      kpe_pkg::RegPathValid: prdata = {31'd0, path_valid_q};
      kpe_pkg::RegSegCount:  prdata = {24'd0, seg_count_q};
      kpe_pkg::RegFirstTime: prdata = first_q;
      kpe_pkg::RegLastTime:  prdata = last_q;
      default:               prdata = '0;
    endcase
  end

  // segments in use, limited to the table
  assign n_c = ({24'd0, seg_count_q} > 32'(MAX_SEGMENTS)) ? CntW'(MAX_SEGMENTS)
                                                          : CntW'(seg_count_q);
  assign mid_c   = low_q + ((high_q - low_q) >> 1);
  assign last_ch = (ch_q == ChW'(NUM_CHANNELS - 1));

  // write items go straight to the memories; bad addresses are dropped
  assign seg_ok  = {24'd0, segment_index_i} < 32'(MAX_SEGMENTS);
  assign ch_ok   = {29'd0, channel_index_i} < 32'(NUM_CHANNELS);
  assign seg_we  = accept && operation_i == kpe_pkg::OpWrTime && seg_ok;
  assign chan_we = accept && operation_i == kpe_pkg::OpWrChan && seg_ok && ch_ok;
  assign pose_we = accept && operation_i == kpe_pkg::OpWrPose && ch_ok;

  assign chan_waddr = EntW'(SegW'(segment_index_i)) * EntW'(NUM_CHANNELS)
                    + EntW'(ChW'(channel_index_i));
  assign chan_raddr = EntW'(idx_q) * EntW'(NUM_CHANNELS) + EntW'(ch_q);
  assign chan_wdata = '{kind: interp_kind_i, clamp: clamp_enable_i,
                        left: left_value_i, right: right_value_i,
                        lslope: left_slope_i, rslope: right_slope_i};

  assign seg_re    = (state_q == kpe_pkg::S_SRCH);
  assign seg_raddr = (low_q < high_q) ? SegW'(mid_c)
                   : ((low_q == '0) ? '0 : SegW'(low_q - CntW'(1)));
  assign chan_re   = (state_q == kpe_pkg::S_CH_RD);
  assign pose_re   = (state_q == kpe_pkg::S_POSE_RD);

  kpe_store #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_store (
    .clk_i         (clk_i),
    .seg_we_i      (seg_we),
    .seg_waddr_i   (SegW'(segment_index_i)),
    .seg_wbegin_i  (begin_time_i),
    .seg_wend_i    (end_time_i),
    .seg_re_i      (seg_re),
    .seg_raddr_i   (seg_raddr),
    .seg_rbegin_o  (seg_rbegin),
    .seg_rend_o    (seg_rend),
    .chan_we_i     (chan_we),
    .chan_waddr_i  (chan_waddr),
    .chan_wdata_i  (chan_wdata),
    .chan_re_i     (chan_re),
    .chan_raddr_i  (chan_raddr),
    .chan_rdata_o  (chan_rdata),
    .pose_we_i     (pose_we),
    .pose_waddr_i  (ChW'(channel_index_i)),
    .pose_wstart_i (left_value_i),
    .pose_wend_i   (right_value_i),
    .pose_re_i     (pose_re),
    .pose_raddr_i  (ch_q),
    .pose_rstart_o (pose_rstart),
    .pose_rend_o   (pose_rend)
  );

  kpe_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == kpe_pkg::S_SEG_WAIT),
    .query_i (t_q),
    .begin_i (seg_rbegin),
    .end_i   (seg_rend),
    .done_o  (div_done),
    .u_o     (div_u),
    .span_o  (div_span)
  );

  assign coef = '{u: u_q, span: span_q, h00: h00_q, h10: h10_q, h01: h01_q, h11: h11_q};

  kpe_chan_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ev_start_q),
    .entry_i (chan_rdata),
    .coef_i  (coef),
    .done_o  (ev_done),
    .value_o (ev_value)
  );

  // phase powers and basis terms
  assign usq = 32'(u_q) * 32'(u_q);
  assign u2u = 32'(u2_q) * 32'(u_q);
  assign us  = $signed({4'd0, u_q});
  assign u2s = $signed({4'd0, u2_q});
  assign u3s = $signed({4'd0, u3_q});

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kpe_pkg::S_IDLE;
      ev_start_q <= 1'b0;
      low_q      <= '0;
      high_q     <= '0;
      ch_q       <= '0;
    end else begin
      ev_start_q <= 1'b0;
      case (state_q)
        kpe_pkg::S_IDLE: begin
          if (accept && operation_i == kpe_pkg::OpEval) begin
            ch_q <= '0;
            if (!path_valid_q) begin
              state_q <= kpe_pkg::S_STATUS;
            end else if (query_time_i <= first_q || n_c == '0
                         || query_time_i >= last_q) begin
              state_q <= kpe_pkg::S_POSE_RD;
            end else begin
              low_q   <= '0;
              high_q  <= n_c;
              state_q <= kpe_pkg::S_SRCH;
            end
          end
        end
        kpe_pkg::S_STATUS:  state_q <= kpe_pkg::S_IDLE;
        kpe_pkg::S_POSE_RD: state_q <= kpe_pkg::S_POSE_OUT;
        kpe_pkg::S_POSE_OUT: begin
          if (last_ch) begin
            state_q <= kpe_pkg::S_IDLE;
          end else begin
            ch_q    <= ch_q + ChW'(1);
            state_q <= kpe_pkg::S_POSE_RD;
          end
        end
        kpe_pkg::S_SRCH: begin
          state_q <= (low_q < high_q) ? kpe_pkg::S_SRCH_CMP : kpe_pkg::S_SEG_WAIT;
        end
        kpe_pkg::S_SRCH_CMP: begin
          if (seg_rbegin <= t_q) begin
            low_q <= mid_q + CntW'(1);
          end else begin
            high_q <= mid_q;
          end
          state_q <= kpe_pkg::S_SRCH;
        end
        kpe_pkg::S_SEG_WAIT: state_q <= kpe_pkg::S_DIV;
        kpe_pkg::S_DIV: begin
          if (div_done) begin
            state_q <= kpe_pkg::S_U2;
          end
        end
        kpe_pkg::S_U2:    state_q <= kpe_pkg::S_U3;
        kpe_pkg::S_U3:    state_q <= kpe_pkg::S_BASIS;
        kpe_pkg::S_BASIS: state_q <= kpe_pkg::S_CH_RD;
        kpe_pkg::S_CH_RD: begin
          ev_start_q <= 1'b1;
          state_q    <= kpe_pkg::S_CH_EVAL;
        end
        kpe_pkg::S_CH_EVAL: begin
          if (ev_done) begin
            if (last_ch) begin
              state_q <= kpe_pkg::S_IDLE;
            end else begin
              ch_q    <= ch_q + ChW'(1);
              state_q <= kpe_pkg::S_CH_RD;
            end
          end
        end
        default: state_q <= kpe_pkg::S_IDLE;
      endcase
    end
  end

  // query datapath
  always_ff @(posedge clk_i) begin
    if (accept && operation_i == kpe_pkg::OpEval) begin
      t_q        <= query_time_i;
      pose_end_q <= !(query_time_i <= first_q || n_c == '0);
    end
    if (state_q == kpe_pkg::S_SRCH) begin
      mid_q <= mid_c;
      idx_q <= seg_raddr;
    end
    if (state_q == kpe_pkg::S_DIV && div_done) begin
      u_q    <= div_u;
      span_q <= div_span;
    end
    if (state_q == kpe_pkg::S_U2) begin
      u2_q <= usq[31:16];
    end
    if (state_q == kpe_pkg::S_U3) begin
      u3_q <= u2u[31:16];
    end
    if (state_q == kpe_pkg::S_BASIS) begin
      h00_q <= hold_basis(u3s + u3s - (u2s + u2s + u2s) + 20'sd65536);
      h10_q <= hold_basis(u3s - u2s - u2s + us);
      h01_q <= hold_basis(u2s + u2s + u2s - (u3s + u3s));
      h11_q <= hold_basis(u3s - u2s);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == kpe_pkg::S_STATUS) || (state_q == kpe_pkg::S_POSE_OUT)
                  || (state_q == kpe_pkg::S_CH_EVAL && ev_done);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == kpe_pkg::S_STATUS) begin
      res_ch_q   <= '0;
      res_val_q  <= '0;
      res_st_q   <= 1'b1;
      res_last_q <= 1'b1;
    end else if (state_q == kpe_pkg::S_POSE_OUT
                 || (state_q == kpe_pkg::S_CH_EVAL && ev_done)) begin
      res_ch_q   <= 3'(ch_q);
      res_st_q   <= 1'b0;
      res_last_q <= last_ch;
      if (state_q == kpe_pkg::S_POSE_OUT) begin
        res_val_q <= pose_end_q ? pose_rend : pose_rstart;
      end else begin
        res_val_q <= ev_value;
      end
    end
  end

  assign result_valid_o  = res_valid_q;
  assign out_channel_o   = res_ch_q;
  assign channel_value_o = res_val_q;
  assign status_o        = res_st_q;
  assign last_of_pose_o  = res_last_q;

  // a refused evaluation is always a single, final transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> last_of_pose_o && out_channel_o == 3'd0)
    else $error("status result not final");

  // nothing follows the final transfer of a pose directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_of_pose_o |=> !result_valid_o)
    else $error("result right after final transfer");

  // an accepted evaluation always occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == kpe_pkg::OpEval |=> busy)
    else $error("evaluation accepted without going busy");

  // write items leave the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i != kpe_pkg::OpEval |=> !busy && !result_valid_o)
    else $error("write item started work");

endmodule

### rtl/kpe_store.sv
// ----------------------------------------------------------------------------
// kpe_store
// Segment, channel and pose memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module kpe_store #(
  parameter int MAX_SEGMENTS = kpe_pkg::MaxSegmentsDef,
  parameter int NUM_CHANNELS = kpe_pkg::NumChannelsDef,
  localparam int SegW = $clog2(MAX_SEGMENTS),
  localparam int ChW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int EntW = $clog2(MAX_SEGMENTS * NUM_CHANNELS)
) (
  input  logic                   clk_i,
  // segment times
  input  logic                   seg_we_i,
  input  logic [SegW-1:0]        seg_waddr_i,
  input  logic [31:0]            seg_wbegin_i,
  input  logic [31:0]            seg_wend_i,
  input  logic                   seg_re_i,
  input  logic [SegW-1:0]        seg_raddr_i,
  output logic [31:0]            seg_rbegin_o,
  output logic [31:0]            seg_rend_o,
  // channel entries
  input  logic                   chan_we_i,
  input  logic [EntW-1:0]        chan_waddr_i,
  input  kpe_pkg::chan_entry_t   chan_wdata_i,
  input  logic                   chan_re_i,
  input  logic [EntW-1:0]        chan_raddr_i,
  output kpe_pkg::chan_entry_t   chan_rdata_o,
  // endpoint poses
  input  logic                   pose_we_i,
  input  logic [ChW-1:0]         pose_waddr_i,
  input  logic [47:0]            pose_wstart_i,
  input  logic [47:0]            pose_wend_i,
  input  logic                   pose_re_i,
  input  logic [ChW-1:0]         pose_raddr_i,
  output logic [47:0]            pose_rstart_o,
  output logic [47:0]            pose_rend_o
);

  logic [63:0]          seg_mem   [MAX_SEGMENTS];
  kpe_pkg::chan_entry_t chan_mem  [MAX_SEGMENTS * NUM_CHANNELS];
  logic [47:0]          start_mem [NUM_CHANNELS];
  logic [47:0]          end_mem   [NUM_CHANNELS];

  // segment times
  always_ff @(posedge clk_i) begin
    if (seg_we_i) begin
      seg_mem[seg_waddr_i] <= {seg_wend_i, seg_wbegin_i};
    end
    if (seg_re_i) begin
      {seg_rend_o, seg_rbegin_o} <= seg_mem[seg_raddr_i];
    end
  end

  // channel entries
  always_ff @(posedge clk_i) begin
    if (chan_we_i) begin
      chan_mem[chan_waddr_i] <= chan_wdata_i;
    end
    if (chan_re_i) begin
      chan_rdata_o <= chan_mem[chan_raddr_i];
    end
  end

  // poses
  always_ff @(posedge clk_i) begin
    if (pose_we_i) begin
      start_mem[pose_waddr_i] <= pose_wstart_i;
      end_mem[pose_waddr_i]   <= pose_wend_i;
    end
    if (pose_re_i) begin
      pose_rstart_o <= start_mem[pose_raddr_i];
      pose_rend_o   <= end_mem[pose_raddr_i];
    end
  end

endmodule

### rtl/kpe_divider.sv
// ----------------------------------------------------------------------------
// kpe_divider
// Segment phase u = ((t - begin) << 16) / span, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module kpe_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] query_i,
  input  logic [31:0] begin_i,
  input  logic [31:0] end_i,
  output logic        done_o,
  output logic [15:0] u_o,
  output logic [31:0] span_o
);

  logic        run_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [15:0] quo_q;
  logic [31:0] span_q;
  logic        done_q;

  logic [31:0] span_c;
  logic [31:0] diff_c;
  logic [32:0] rem2_c;
  logic        fit_c;

  assign span_c = (end_i > begin_i) ? end_i - begin_i : '0;
  assign diff_c = query_i - begin_i;
  assign rem2_c = {rem_q, 1'b0};
  assign fit_c  = rem2_c >= {1'b0, span_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (span_c == '0 || query_i <= begin_i || diff_c >= span_c) begin
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
          cnt_q <= 5'd16;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division datapath; a phase at or past the end saturates
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      span_q <= span_c;
      rem_q  <= diff_c;
      if (span_c == '0 || query_i <= begin_i) begin
        quo_q <= '0;
      end else if (diff_c >= span_c) begin
        quo_q <= '1;
      end else begin
        quo_q <= '0;
      end
    end else if (run_q) begin
      rem_q <= fit_c ? 32'(rem2_c - {1'b0, span_q}) : rem2_c[31:0];
      quo_q <= {quo_q[14:0], fit_c};
    end
  end

  assign done_o = done_q;
  assign u_o    = quo_q;
  assign span_o = span_q;

endmodule

### rtl/kpe_chan_eval.sv
// ----------------------------------------------------------------------------
// kpe_chan_eval
// One channel value through a shared 48x18 multiplier, ten products a channel.
// ----------------------------------------------------------------------------
module kpe_chan_eval (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  kpe_pkg::chan_entry_t entry_i,
  input  kpe_pkg::coef_t       coef_i,
  output logic                 done_o,
  output logic [47:0]          value_o
);

  localparam logic [3:0] StLinL  = 4'd0;
  localparam logic [3:0] StLinR  = 4'd1;
  localparam logic [3:0] StD0Hi  = 4'd2;
  localparam logic [3:0] StD0Lo  = 4'd3;
  localparam logic [3:0] StD1Hi  = 4'd4;
  localparam logic [3:0] StD1Lo  = 4'd5;
  localparam logic [3:0] StH00   = 4'd6;
  localparam logic [3:0] StH01   = 4'd7;
  localparam logic [3:0] StH10   = 4'd8;
  localparam logic [3:0] StH11   = 4'd9;
  localparam logic [3:0] StFinal = 4'd11;

  localparam logic [47:0] ValMax = {1'b0, {47{1'b1}}};
  localparam logic [47:0] ValMin = {1'b1, {47{1'b0}}};

  logic               run_q;
  logic [3:0]         step_q;
  logic [3:0]         tag_q;
  logic               acc_q;
  logic signed [65:0] prod_q;
  logic signed [51:0] lin_q;
  logic signed [65:0] d0_q;
  logic signed [65:0] d1_q;
  logic signed [51:0] v_q;
  logic               done_q;
  logic [47:0]        value_q;

  logic signed [47:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [65:0] prod_d;
  logic signed [49:0] fl;
  logic signed [51:0] l52, r52, lo52, hi52, herm, pick;
  logic               d_ok, v_ok;

  // operand selection for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      StLinL: begin
        mul_a = $signed(entry_i.left);
        mul_b = $signed({1'b0, 17'(17'h10000 - {1'b0, coef_i.u})});
      end
      StLinR: begin
        mul_a = $signed(entry_i.right);
        mul_b = $signed({2'b00, coef_i.u});
      end
      StD0Hi: begin
        mul_a = $signed(entry_i.lslope);
        mul_b = $signed({2'b00, coef_i.span[31:16]});
      end
      StD0Lo: begin
        mul_a = $signed(entry_i.lslope);
        mul_b = $signed({2'b00, coef_i.span[15:0]});
      end
      StD1Hi: begin
        mul_a = $signed(entry_i.rslope);
        mul_b = $signed({2'b00, coef_i.span[31:16]});
      end
      StD1Lo: begin
        mul_a = $signed(entry_i.rslope);
        mul_b = $signed({2'b00, coef_i.span[15:0]});
      end
      StH00: begin
        mul_a = $signed(entry_i.left);
        mul_b = coef_i.h00;
      end
      StH01: begin
        mul_a = $signed(entry_i.right);
        mul_b = coef_i.h01;
      end
      StH10: begin
        mul_a = $signed(d0_q[47:0]);
        mul_b = coef_i.h10;
      end
      StH11: begin
        mul_a = $signed(d1_q[47:0]);
        mul_b = coef_i.h11;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;
  // floor by 2^16
  assign fl = prod_q[65:16];

  // sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      acc_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      acc_q  <= run_q && (step_q <= StH11);
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= StLinL;
      end else if (run_q) begin
        if (step_q == StFinal) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 4'd1;
        end
      end
    end
  end

  // product register and accumulation of the previous product
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    tag_q  <= step_q;
    if (acc_q) begin
      case (tag_q)
        StLinL:  lin_q <= 52'(fl);
        StLinR:  lin_q <= lin_q + 52'(fl);
        StD0Hi:  d0_q  <= prod_q;
        StD0Lo:  d0_q  <= d0_q + 66'(fl);
        StD1Hi:  d1_q  <= prod_q;
        StD1Lo:  d1_q  <= d1_q + 66'(fl);
        StH00:   v_q   <= 52'(fl);
        StH01:   v_q   <= v_q + 52'(fl);
        StH10:   v_q   <= v_q + 52'(fl);
        StH11:   v_q   <= v_q + 52'(fl);
        default: v_q   <= v_q;
      endcase
    end
  end

  // select the kind, fall back to linear on overflow, clamp and saturate
  always_comb begin
    d_ok = ((&d0_q[65:47]) || !(|d0_q[65:47])) && ((&d1_q[65:47]) || !(|d1_q[65:47]));
    v_ok = (&v_q[51:47]) || !(|v_q[51:47]);
    l52  = 52'($signed(entry_i.left));
    r52  = 52'($signed(entry_i.right));
    lo52 = (l52 < r52) ? l52 : r52;
    hi52 = (l52 < r52) ? r52 : l52;
    herm = v_q;
    if (entry_i.clamp) begin
      if (herm < lo52) herm = lo52;
      if (herm > hi52) herm = hi52;
    end
    case (entry_i.kind)
      kpe_pkg::KindLinear:  pick = lin_q;
      kpe_pkg::KindHermite: pick = (d_ok && v_ok) ? herm : lin_q;
      default:              pick = l52;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (run_q && step_q == StFinal) begin
      if ((&pick[51:47]) || !(|pick[51:47])) begin
        value_q <= pick[47:0];
      end else begin
        value_q <= pick[51] ? ValMin : ValMax;
      end
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule
